// ===== hw/rtl/plab_pkg.sv =====
// package for the polygon loop adjacency builder: widths, action codes,
// row type and the join request passed from the loop tracker to the matrix
// no dependencies
`default_nettype none

package plab_pkg;

  localparam int unsigned NumVertices = 32;
  localparam int unsigned VertexW     = 5;
  localparam int unsigned CountW      = 11;
  localparam int unsigned EdgeW       = 10;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 80;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef logic [NumVertices-1:0] row_t;
  typedef logic [VertexW-1:0]     vertex_t;

  typedef struct packed {
    logic    clear;
    logic    join_prev;
    logic    join_first;
    vertex_t prev;
    vertex_t first;
    vertex_t vert;
  } join_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/polygon_loop_adjacency_builder_unit.sv =====
// polygon loop adjacency builder: input register, single-pass update, result register
// throughput: one item per cycle unless the master side stalls, set by the single
// update pass between the two registers
// reset: asynchronous, clears matrix, seen mask, count and loop state at once
// depends on plab_pkg, plab_loop_ctrl, plab_adj_matrix
`default_nettype none

module polygon_loop_adjacency_builder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [plab_pkg::InDataW-1:0]  s_axis_tdata_i,  // action[1:0], vertex[6:2], zero pad
  input  logic                          s_axis_tlast_i,  // loop_last
  // master side
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // neighbour_mask[31:0], has_neighbours[32], seen_mask[64:33], edge_count[74:65], zero pad
  output logic [plab_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import plab_pkg::*;

  // input register
  logic    in_valid_q;
  action_e in_action_q;
  vertex_t in_vertex_q;
  logic    in_last_q;

  // result register
  logic              out_valid_q;
  row_t              out_mask_q;
  logic              out_has_q;
  row_t              out_seen_q;
  logic [EdgeW-1:0]  out_edge_q;

  logic              advance;
  logic              in_take;
  join_req_t         req;
  row_t              seen_next;
  row_t              query_row;
  row_t              mask_d;
  logic [CountW-1:0] count_next;

  // the item moves on when the result register is free or being emptied
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  plab_loop_ctrl u_loop_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .action_i    (in_action_q),
    .vertex_i    (in_vertex_q),
    .last_i      (in_last_q),
    .req_o       (req),
    .seen_next_o (seen_next)
  );

  plab_adj_matrix u_adj_matrix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .row_o        (query_row),
    .count_next_o (count_next)
  );

  // only a query reports a neighbour row
  assign mask_d = (in_action_q == ACT_QUERY) ? query_row : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // payload of the input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= action_e'(s_axis_tdata_i[1:0]);
      in_vertex_q <= s_axis_tdata_i[6:2];
      in_last_q   <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, seen mask and count taken after this item's update
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mask_q <= mask_d;
      out_has_q  <= |mask_d;
      out_seen_q <= seen_next;
      out_edge_q <= count_next[CountW-1:1];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_edge_q, out_seen_q, out_has_q, out_mask_q};

endmodule

`default_nettype wire

// ===== hw/rtl/plab_loop_ctrl.sv =====
// loop tracker: first and previous vertex of the open loop, seen-vertex mask,
// issues the join requests for each added vertex
// depends on plab_pkg
`default_nettype none

module plab_loop_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  plab_pkg::action_e   action_i,
  input  plab_pkg::vertex_t   vertex_i,
  input  logic                last_i,
  output plab_pkg::join_req_t req_o,
  output plab_pkg::row_t      seen_next_o
);
  import plab_pkg::*;

  vertex_t first_q, first_d;
  vertex_t prev_q, prev_d;
  logic    inside_q, inside_d;
  row_t    seen_q, seen_d;

  always_comb begin
    first_d        = first_q;
    prev_d         = prev_q;
    inside_d       = inside_q;
    seen_d         = seen_q;
    req_o          = '0;
    req_o.vert     = vertex_i;
    req_o.prev     = prev_q;
    req_o.first    = first_q;
    if (fire_i) begin
      case (action_i)
        ACT_CLEAR: begin
          first_d     = '0;
          prev_d      = '0;
          inside_d    = 1'b0;
          seen_d      = '0;
          req_o.clear = 1'b1;
        end
        ACT_ADD: begin
          seen_d = seen_q | (row_t'(1) << vertex_i);
          if (!inside_q) begin
            // opening vertex of a loop
            first_d  = vertex_i;
            prev_d   = vertex_i;
            inside_d = !last_i;
          end else begin
            prev_d          = vertex_i;
            req_o.join_prev = 1'b1;
            if (last_i) begin
              req_o.join_first = 1'b1;
              inside_d         = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign seen_next_o = seen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      prev_q   <= '0;
      inside_q <= 1'b0;
      seen_q   <= '0;
    end else begin
      first_q  <= first_d;
      prev_q   <= prev_d;
      inside_q <= inside_d;
      seen_q   <= seen_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plab_adj_matrix.sv =====
// adjacency bit matrix held as one register row per vertex, plus the count
// of set bits; symmetric, so row v alone answers both directions of a join
// depends on plab_pkg
`default_nettype none

module plab_adj_matrix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plab_pkg::join_req_t req_i,
  output plab_pkg::row_t      row_o,
  output logic [plab_pkg::CountW-1:0] count_next_o
);
  import plab_pkg::*;

  row_t              rows_q [NumVertices];
  row_t              rows_d [NumVertices];
  logic [CountW-1:0] count_q, count_d;
  row_t              row_v;
  logic              hit_prev, hit_first;
  logic [2:0]        inc_prev, inc_first;

  assign row_v = rows_q[req_i.vert];
  assign row_o = row_v;

  always_comb begin
    hit_prev  = row_v[req_i.prev];
    // the prev join of the same request may already have set the closing bit
    hit_first = row_v[req_i.first] || (req_i.join_prev && (req_i.first == req_i.prev));
    inc_prev  = '0;
    inc_first = '0;
    if (req_i.join_prev && !hit_prev) begin
      inc_prev = (req_i.prev == req_i.vert) ? 3'd1 : 3'd2;
    end
    if (req_i.join_first && !hit_first) begin
      inc_first = (req_i.first == req_i.vert) ? 3'd1 : 3'd2;
    end
    if (req_i.clear) begin
      count_d = '0;
    end else begin
      count_d = count_q + CountW'(inc_prev) + CountW'(inc_first);
    end
  end

  assign count_next_o = count_d;

  always_comb begin
    for (int r = 0; r < NumVertices; r++) begin
      rows_d[r] = rows_q[r];
      if (req_i.join_prev) begin
        if (vertex_t'(r) == req_i.prev) rows_d[r][req_i.vert] = 1'b1;
        if (vertex_t'(r) == req_i.vert) rows_d[r][req_i.prev] = 1'b1;
      end
      if (req_i.join_first) begin
        if (vertex_t'(r) == req_i.first) rows_d[r][req_i.vert] = 1'b1;
        if (vertex_t'(r) == req_i.vert)  rows_d[r][req_i.first] = 1'b1;
      end
      if (req_i.clear) rows_d[r] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int r = 0; r < NumVertices; r++) rows_q[r] <= '0;
    end else begin
      count_q <= count_d;
      for (int r = 0; r < NumVertices; r++) rows_q[r] <= rows_d[r];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plab_checker.sv =====
// port-level checker for the polygon loop adjacency builder and its bind
// depends on plab_pkg and polygon_loop_adjacency_builder_unit
`default_nettype none

module plab_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [plab_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import plab_pkg::*;

  logic [31:0] nmask, seen;
  logic        has;

  assign nmask = m_axis_tdata_o[31:0];
  assign has   = m_axis_tdata_o[32];
  assign seen  = m_axis_tdata_o[64:33];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a fresh result always follows an input transfer through the input and result registers
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result without input transfer");

  // only seen vertices can be neighbours
  a_nbr_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((nmask & ~seen) == '0))
    else $error("neighbour outside seen mask");

  // flag agrees with the mask
  a_has_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (has == (nmask != '0)))
    else $error("has_neighbours disagrees with mask");

endmodule

bind polygon_loop_adjacency_builder_unit plab_checker u_plab_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// ===== sim/plab_adjacency_check_pkg.sv =====
`timescale 1ns / 100ps
// scoreboard for the polygon loop adjacency builder: a predictor of the matrix,
// seen mask and bit count, and a queue of the neighbour reports still to arrive
// depends on plab_pkg
package plab_adjacency_check_pkg;

  import plab_pkg::*;

  typedef struct {
    row_t              neighbours;
    logic              found;
    row_t              visited;
    logic [EdgeW-1:0]  edges;
  } neighbour_report_t;

  class adjacency_checker;
    row_t              rows [NumVertices];
    row_t              visited;
    logic [CountW-1:0] bit_total;
    vertex_t           loop_head;
    vertex_t           loop_tail;
    logic              loop_open;
    neighbour_report_t pending_reports [$];
    int unsigned       items_noted;
    int unsigned       reports_checked;
    int unsigned       queries;
    int unsigned       queries_found;
    int unsigned       clears;
    int unsigned       peak_edges;
    int unsigned       mismatches;

    function new();
      wipe();
      items_noted     = 0;
      reports_checked = 0;
      queries         = 0;
      queries_found   = 0;
      clears          = 0;
      peak_edges      = 0;
      mismatches      = 0;
    endfunction

    function void wipe();
      foreach (rows[i]) rows[i] = '0;
      visited   = '0;
      bit_total = '0;
      loop_head = '0;
      loop_tail = '0;
      loop_open = 1'b0;
    endfunction

    // both directions; a self-join lands on one bit, already set bits are not recounted
    function void link(vertex_t a, vertex_t b);
      if (!rows[a][b]) begin
        rows[a][b] = 1'b1;
        bit_total++;
      end
      if (!rows[b][a]) begin
        rows[b][a] = 1'b1;
        bit_total++;
      end
    endfunction

    // an accepted input transfer: update the copy of the state, queue its report
    function void note_item(action_e act, vertex_t v, logic last);
      neighbour_report_t r;
      r.neighbours = '0;
      r.found      = 1'b0;
      items_noted++;
      // five-bit vertex numbers always fall inside the 32-row matrix
      case (act)
        ACT_CLEAR: begin
          wipe();
          clears++;
        end
        ACT_ADD: begin
          visited[v] = 1'b1;
          if (!loop_open) begin
            loop_head = v;
            loop_tail = v;
            loop_open = !last;
          end else begin
            link(loop_tail, v);
            loop_tail = v;
            if (last) begin
              link(v, loop_head);
              loop_open = 1'b0;
            end
          end
        end
        ACT_QUERY: begin
          queries++;
          r.neighbours = rows[v];
          r.found      = |rows[v];
          if (r.found) queries_found++;
        end
        default: ;
      endcase
      r.visited = visited;
      r.edges   = bit_total[CountW-1:1];
      if (r.edges > peak_edges) peak_edges = r.edges;
      pending_reports.insert(pending_reports.size(), r);
    endfunction

    // an accepted output transfer against the oldest queued report
    function void check_report(logic [OutDataW-1:0] data);
      neighbour_report_t exp_r;
      row_t              got_neighbours;
      logic              got_found;
      row_t              got_visited;
      logic [EdgeW-1:0]  got_edges;
      got_neighbours = data[31:0];
      got_found      = data[32];
      got_visited    = data[64:33];
      got_edges      = data[74:65];
      reports_checked++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        return;
      end
      exp_r = pending_reports.pop_front();
      if (got_neighbours !== exp_r.neighbours) begin
        mismatches++;
        $display("%0t: neighbour_mask expected %h actual %h", $time, exp_r.neighbours,
                 got_neighbours);
      end
      if (got_found !== exp_r.found) begin
        mismatches++;
        $display("%0t: has_neighbours expected %b actual %b", $time, exp_r.found, got_found);
      end
      if (got_visited !== exp_r.visited) begin
        mismatches++;
        $display("%0t: seen_mask expected %h actual %h", $time, exp_r.visited, got_visited);
      end
      if (got_edges !== exp_r.edges) begin
        mismatches++;
        $display("%0t: edge_count expected %0d actual %0d", $time, exp_r.edges, got_edges);
      end
    endfunction
  endclass

endpackage

// ===== sim/polygon_loop_adjacency_builder_unit_test.sv =====
`timescale 1ns / 100ps
// self-checking test of polygon_loop_adjacency_builder_unit: directed loops, then
// random loops, queries, clears and noise, with random gaps and stalls on both sides
// depends on plab_pkg, plab_adjacency_check_pkg and the rtl of the unit
module polygon_loop_adjacency_builder_unit_test;

  import plab_pkg::*;
  import plab_adjacency_check_pkg::*;

  localparam int unsigned HalfPeriod   = 5;
  localparam int unsigned ResetCycles  = 10;
  localparam int unsigned RandomItems  = 2000;
  localparam int unsigned IdleLimit    = 2000;  // cycles with no transfer on either side
  localparam int unsigned SettleCycles = 8;     // a margin over the path through the input and result registers

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  adjacency_checker board = new();

  // sender pacing: runs of items with or without gaps
  int unsigned send_run_left = 0;
  bit          send_calm     = 1'b0;
  int unsigned idle_cycles   = 0;

  always #HalfPeriod clk = ~clk;

  polygon_loop_adjacency_builder_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),   // action[1:0], vertex[6:2], zero pad
    .s_axis_tlast_i  (s_axis_tlast),   // loop_last
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    // neighbour_mask[31:0], has_neighbours[32], seen_mask[64:33], edge_count[74:65]
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // every result transfer goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      board.check_report(m_axis_tdata);
    end
  end

  // watchdog: a long stretch with no transfer on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               idle_cycles, board.pending_reports.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: a random stall before each result, with calm stretches of none
  initial begin : result_sink
    int unsigned stall;
    int unsigned run_left;
    bit          calm;
    run_left = 0;
    calm     = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (run_left == 0) begin
        calm     = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(20, 150);
      end
      run_left--;
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // one input transfer; valid stays high between back-to-back items
  task automatic send_item(action_e act, vertex_t v, logic last);
    int unsigned gap;
    if (send_run_left == 0) begin
      send_calm     = ($urandom_range(0, 3) == 0);
      send_run_left = $urandom_range(20, 150);
    end
    send_run_left--;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, v, act};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    board.note_item(act, v, last);
  endtask

  // sender holds off until every queued result has come back
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
  endtask

  function automatic vertex_t any_vertex();
    return vertex_t'($urandom_range(0, NumVertices - 1));
  endfunction

  // a well-formed loop; narrow ones revisit a few vertices for repeated joins and self-loops
  task automatic send_loop(bit close_it);
    int unsigned len;
    int unsigned k;
    bit          narrow;
    vertex_t     v;
    len    = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8);
    narrow = ($urandom_range(0, 4) == 0);
    for (k = 0; k < len; k++) begin
      v = narrow ? vertex_t'($urandom_range(0, 3)) : any_vertex();
      // queries in mid-loop must not disturb the open loop
      if ($urandom_range(0, 9) == 0) begin
        send_item(ACT_QUERY, any_vertex(), 1'($urandom_range(0, 1)));
      end
      send_item(ACT_ADD, v, close_it && (k == len - 1));
    end
  endtask

  task automatic run_directed();
    send_item(ACT_NONE,  5'd0,  1'b0);  // unused action on empty state
    send_item(ACT_QUERY, 5'd0,  1'b0);  // nothing joined yet
    send_item(ACT_ADD,   5'd31, 1'b1);  // loop of one vertex: seen, no edge
    send_item(ACT_QUERY, 5'd31, 1'b1);
    send_item(ACT_ADD,   5'd0,  1'b0);  // triangle over both extremes
    send_item(ACT_ADD,   5'd31, 1'b0);
    send_item(ACT_ADD,   5'd5,  1'b1);
    send_item(ACT_QUERY, 5'd0,  1'b0);
    send_item(ACT_QUERY, 5'd31, 1'b0);
    send_item(ACT_ADD,   5'd7,  1'b0);  // self-loop: one matrix bit
    send_item(ACT_ADD,   5'd7,  1'b1);
    send_item(ACT_QUERY, 5'd7,  1'b0);
    send_item(ACT_ADD,   5'd0,  1'b0);  // repeated join, count unchanged
    send_item(ACT_ADD,   5'd31, 1'b1);
    send_item(ACT_ADD,   5'd10, 1'b0);  // loop left open for a while
    send_item(ACT_ADD,   5'd11, 1'b0);
    send_item(ACT_QUERY, 5'd10, 1'b1);
    send_item(ACT_NONE,  5'd11, 1'b1);  // unused action ignores its last flag
    send_item(ACT_ADD,   5'd12, 1'b1);  // closes back to vertex 10
    send_item(ACT_QUERY, 5'd12, 1'b0);
    send_item(ACT_ADD,   5'd20, 1'b0);  // clear with a loop still open
    send_item(ACT_CLEAR, 5'd31, 1'b1);
    send_item(ACT_QUERY, 5'd0,  1'b0);
  endtask

  task automatic run_random();
    int unsigned pick;
    bit          paused;
    paused = 1'b0;
    while (board.items_noted < ResetCycles + RandomItems) begin
      pick = $urandom_range(0, 999);
      if (pick < 600) begin
        send_loop(1'b1);
      end else if (pick < 850) begin
        send_item(ACT_QUERY, any_vertex(), 1'($urandom_range(0, 1)));
      end else if (pick < 930) begin
        send_item(ACT_NONE, any_vertex(), 1'($urandom_range(0, 1)));
      end else if (pick < 935) begin
        // broken loop cut short by a clear
        send_loop(1'b0);
        send_item(ACT_CLEAR, any_vertex(), 1'($urandom_range(0, 1)));
      end else if (pick < 995) begin
        // left open: the next loop carries on from it
        send_loop(1'b0);
      end else begin
        send_item(ACT_CLEAR, any_vertex(), 1'($urandom_range(0, 1)));
      end
      if (!paused && board.items_noted > RandomItems / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    hold_until_drained();
    run_random();
    hold_until_drained();
    repeat (SettleCycles) @(posedge clk);
    $display("run covered %0d input transfers and %0d results: %0d queries (%0d with neighbours)",
             board.items_noted, board.reports_checked, board.queries, board.queries_found);
    $display("%0d clears, edge count peaked at %0d, %0d mismatches",
             board.clears, board.peak_edges, board.mismatches);
    if (board.mismatches == 0 && board.pending_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
